@@ design/smx_pkg.sv @@
// Shared types, constants and a function for the softmax block.
`default_nettype none
package smx_pkg;
   localparam int MaxLen = 64;
   localparam int AddrW = 6;
   localparam int CntW = 7;
   localparam int SumW = 24;
   localparam logic [16:0] Log2eQ16 = 17'd94548;

   typedef struct packed {
      logic clear;      // clear count, max, sum and overflow flag
      logic load;       // store req element
      logic exp_start;  // launch exp pipe at rd index
      logic acc;        // add exp result into sum
      logic div_start;  // start divider with exp result
      logic idx_clr;
      logic idx_inc;
   } smx_cmd_type;

   typedef struct packed {
      logic [CntW-1:0] count;
      logic [CntW-1:0] idx;
      logic exp_done;
      logic div_done;
   } smx_sts_type;

   function automatic logic [16:0] pow2_neg(input logic [4:0] i);
      logic [16:0] v;
      begin
         case (i)
            5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
            5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
            5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
            5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
            5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
            5'd15: v = 17'd34219; 5'd16: v = 17'd32768;
            default: v = 17'd32768;
         endcase
         return v;
      end
   endfunction
endpackage
`default_nettype wire

@@ design/smx_exp.sv @@
// Three-stage exp(-n/256) unit, Q1.16 result.
`default_nettype none
module smx_exp (
   input  wire         clock,
   input  wire         start,
   input  wire  [15:0] n,
   output logic        done,
   output logic [16:0] e
);
   import smx_pkg::*;
   logic [2:0]  vld_ff, vld_in;
   logic [33:0] y_ff, y_in;
   logic [16:0] hi_ff, hi_in, dl_ff, dl_in, hi2_ff, hi2_in;
   logic [11:0] r_ff, r_in;
   logic [17:0] k_ff, k_in, k2_ff, k2_in;
   logic [28:0] prod_ff, prod_in;
   logic [25:0] yy;
   logic [16:0] lo, m;

   always_comb begin
      vld_in  = {vld_ff[1:0], start};
      y_in    = {1'b0, n} * Log2eQ16 + 34'd128;
      yy      = y_ff[33:8];
      hi_in   = pow2_neg({1'b0, yy[15:12]});
      lo      = pow2_neg({1'b0, yy[15:12]} + 5'd1);
      dl_in   = hi_in - lo;
      r_in    = yy[11:0];
      k_in    = {8'd0, yy[25:16]};
      prod_in = dl_ff * r_ff + 29'd2048;
      k2_in   = k_ff;
      // hi_ff pairs with prod_ff one stage late: hold a copy
      hi2_in  = hi_ff;
      m       = hi2_ff - prod_ff[28:12];
      done    = vld_ff[2];
      e       = (k2_ff >= 18'd17) ? 17'd0 : (m >> k2_ff[4:0]);
   end

   always_ff @(posedge clock) begin
      vld_ff <= vld_in;
      y_ff   <= y_in;
      hi_ff  <= hi_in;
      dl_ff  <= dl_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      prod_ff <= prod_in;
      k2_ff  <= k2_in;
      hi2_ff <= hi2_in;
   end
endmodule
`default_nettype wire

@@ design/smx_div.sv @@
// Restoring divider, one quotient bit per cycle, rounded and saturated.
`default_nettype none
module smx_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [16:0] e,
   input  wire  [23:0] sum,
   output logic        done,
   output logic [15:0] q
);
   import smx_pkg::*;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] num_ff, num_in;  // shifting dividend
   logic [24:0] rem_ff, rem_in;
   logic [23:0] d_ff, d_in;
   logic [32:0] quo_ff, quo_in;
   logic [25:0] trial;

   always_comb begin
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      num_in = num_ff; rem_in = rem_ff; d_in = d_ff; quo_in = quo_ff;
      trial = '0;
      if (start) begin
         // e * 65536 plus half the divisor for rounding
         num_in  = {e, 16'd0} + {10'd0, sum[23:1]};
         rem_in  = '0; d_in = sum; quo_in = '0;
         cnt_in  = 6'd33; busy_in = 1'b1;
      end else if (busy_ff) begin
         trial  = {rem_ff, num_ff[32]} - {2'b0, d_ff};
         num_in = {num_ff[31:0], 1'b0};
         if (!trial[25]) begin
            rem_in = trial[24:0]; quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[23:0], num_ff[32]}; quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
      done = done_ff;
      q = (d_ff == 24'd0) ? 16'd0 : ((|quo_ff[32:16]) ? 16'hFFFF : quo_ff[15:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; d_ff <= d_in; quo_ff <= quo_in;
   end
endmodule
`default_nettype wire

@@ design/smx_dp.sv @@
// Datapath: element store, running max, exp unit, sum and divider.
`default_nettype none
module smx_dp (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  smx_pkg::smx_cmd_type cmd,
   output smx_pkg::smx_sts_type       sts,
   input  wire  [15:0]                req_value,
   output logic [15:0]                probability,
   output logic                       trunc
);
   import smx_pkg::*;
   logic [15:0] mem [MaxLen];
   logic [15:0] rd_ff;
   logic [CntW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic signed [15:0] max_ff, max_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic ovf_ff, ovf_in;
   logic [15:0] n;
   logic [16:0] e;
   logic exp_done, div_done;
   logic full;

   assign full = (cnt_ff == CntW'(MaxLen));
   assign n = 16'(max_ff - $signed(rd_ff));

   smx_exp u_exp (.clock(clock), .start(cmd.exp_start), .n(n), .done(exp_done), .e(e));
   smx_div u_div (.clock(clock), .reset(reset), .start(cmd.div_start), .e(e),
                  .sum(sum_ff), .done(div_done), .q(probability));

   always_comb begin
      cnt_in = cnt_ff; max_in = max_ff; sum_in = sum_ff; ovf_in = ovf_ff; idx_in = idx_ff;
      if (cmd.load) begin
         if (full) ovf_in = 1'b1;
         else begin
            cnt_in = cnt_ff + 1'b1;
            if ($signed(req_value) > max_ff) max_in = $signed(req_value);
         end
      end
      if (cmd.acc) sum_in = sum_ff + SumW'(e);
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      if (cmd.clear) begin
         cnt_in = '0; max_in = 16'sh8000; sum_in = '0; ovf_in = 1'b0;
      end
      sts.count = cnt_ff; sts.idx = idx_ff;
      sts.exp_done = exp_done; sts.div_done = div_done;
      trunc = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) mem[cnt_ff[AddrW-1:0]] <= req_value;
      rd_ff <= mem[idx_in[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; max_ff <= 16'sh8000; sum_ff <= '0; ovf_ff <= 1'b0; idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; max_ff <= max_in; sum_ff <= sum_in; ovf_ff <= ovf_in;
         idx_ff <= idx_in;
      end
   end
endmodule
`default_nettype wire

@@ design/smx_ctrl.sv @@
// Controller: load, exp-sum pass, divide pass, output handshake.
`default_nettype none
module smx_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire                        req_last,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic                       rsp_last,
   output smx_pkg::smx_cmd_type       cmd,
   input  wire  smx_pkg::smx_sts_type sts
);
   import smx_pkg::*;
   typedef enum logic [6:0] {
      S_LOAD  = 7'b0000001, S_SUMRD = 7'b0000010, S_SUMX = 7'b0000100,
      S_SUMW  = 7'b0001000, S_DIVRD = 7'b0010000, S_DIVX = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;
   state_type st_ff, st_in;
   logic vld_ff, vld_in, lst_ff, lst_in;

   always_comb begin
      st_in = st_ff; vld_in = vld_ff; lst_in = lst_ff;
      cmd = '0;
      req_tready = (st_ff == S_LOAD);
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (st_ff)
         S_LOAD: if (req_tvalid) begin
            cmd.load = 1'b1;
            if (req_last) begin st_in = S_SUMRD; cmd.idx_clr = 1'b1; end
         end
         S_SUMRD: begin   // read data valid next cycle
            if (sts.idx == sts.count) begin
               st_in = S_DIVRD; cmd.idx_clr = 1'b1;
            end else st_in = S_SUMX;
         end
         S_SUMX: begin cmd.exp_start = 1'b1; st_in = S_SUMW; end
         S_SUMW: if (sts.exp_done) begin
            cmd.acc = 1'b1; cmd.idx_inc = 1'b1; st_in = S_SUMRD;
         end
         S_DIVRD: begin
            if (sts.idx == sts.count) begin
               st_in = S_LOAD; cmd.clear = 1'b1; cmd.idx_clr = 1'b1;
            end else if (!vld_ff || rsp_tready) begin
               cmd.exp_start = 1'b1; st_in = S_DIVX;
            end
         end
         S_DIVX: if (sts.exp_done) begin cmd.div_start = 1'b1; st_in = S_OUT; end
         S_OUT: if (sts.div_done) begin
            vld_in = 1'b1; lst_in = (sts.idx + 1'b1 == sts.count);
            cmd.idx_inc = 1'b1; st_in = S_DIVRD;
         end
         default: st_in = S_LOAD;
      endcase
      rsp_tvalid = vld_ff; rsp_last = lst_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; vld_ff <= 1'b0; lst_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; lst_ff <= lst_in;
      end
   end

   a_nodiv_while_pending: assert property (@(posedge clock) disable iff (reset)
      (sts.div_done |-> (!vld_ff || rsp_tready))) else $error("result overwritten");
   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      (req_tready |-> st_ff == S_LOAD)) else $error("ready outside load");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (sts.idx <= sts.count)) else $error("index past count");
endmodule
`default_nettype wire

@@ design/softmax_vector.sv @@
// Top level of the streaming softmax block.
// Elements load at one per cycle into a 64-entry store while the maximum is
// tracked; the element with tlast closes the vector. Then an exp-sum pass
// reads each element from the store into the 3-stage exp unit and sums the
// results; a divide pass reruns the exp unit and the 33-step serial divider
// per element, waiting while the output is stalled; new input is held off
// until the divide pass ends; the final result may still be waiting then.
`default_nettype none
module softmax_vector (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // value
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // probability
   output logic        rsp_tlast,
   output logic        rsp_tuser    // truncated
);
   import smx_pkg::*;
   smx_cmd_type cmd;
   smx_sts_type sts;
   logic [15:0] prob;
   logic trunc;
   logic [15:0] data_ff;
   logic usr_ff;

   smx_ctrl u_ctrl (.clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_last(req_tlast), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_last(rsp_tlast), .cmd(cmd), .sts(sts));
   smx_dp u_dp (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_value(req_tdata), .probability(prob), .trunc(trunc));

   always_ff @(posedge clock) begin
      if (sts.div_done) begin
         data_ff <= prob; usr_ff <= trunc;
      end
   end
   assign rsp_tdata = data_ff;
   assign rsp_tuser = usr_ff;
endmodule
`default_nettype wire

@@ tb/tb_softmax_vector.sv @@
// Self-checking testbench for the streaming softmax block.
`timescale 1ns / 100ps
`default_nettype none
module tb_softmax_vector;
   import smx_pkg::*;

   typedef struct packed {
      logic [15:0] prob;
      logic        last;
      logic        trunc;
   } prob_item_type;

   // Directed row: element, last flag, and an optional typed-in probability.
   typedef struct packed {
      logic [15:0] value;
      logic        last;
      logic        has_prob;
      logic [15:0] prob;
   } dir_row_type;

   localparam int DirRows = 20;
   localparam int RandItems = 320;
   localparam int WatchLimit = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   softmax_vector u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),   // value
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),   // probability
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)    // truncated
   );

   always #10 clock = ~clock;

   // predictor state
   logic [15:0] vec_store [MaxLen];
   int          vec_count;
   logic signed [15:0] vec_max;
   logic        vec_dropped;

   prob_item_type prob_queue [$];
   logic [16:0] fixed_prob [$];   // bit 16 set when the row carries a typed value

   int  mismatches = 0;
   int  rsp_seen = 0;
   int  vectors_closed = 0;
   int  watch = 0;
   bit  quiet_idle = 1'b0;

   function automatic logic [16:0] pow2_tab(input int i);
      case (i)
         0: return 17'd65536;  1: return 17'd62757;  2: return 17'd60097;
         3: return 17'd57549;  4: return 17'd55109;  5: return 17'd52773;
         6: return 17'd50535;  7: return 17'd48393;  8: return 17'd46341;
         9: return 17'd44376;  10: return 17'd42495; 11: return 17'd40693;
         12: return 17'd38968; 13: return 17'd37316; 14: return 17'd35734;
         15: return 17'd34219; default: return 17'd32768;
      endcase
   endfunction

   // exp(-n/256) in Q1.16 through 2^-y table with linear interpolation
   function automatic logic [16:0] exp_neg(input logic [15:0] n);
      logic [47:0] y;
      logic [31:0] k, f, j, r, hi, lo, m;
      y = ({32'd0, n} * 48'd94548 + 48'd128) >> 8;
      k = y[47:16];
      f = {16'd0, y[15:0]};
      j = f >> 12;
      r = f & 32'hFFF;
      hi = {15'd0, pow2_tab(int'(j))};
      lo = {15'd0, pow2_tab(int'(j) + 1)};
      m = hi - (((hi - lo) * r + 32'd2048) >> 12);
      if (k >= 17) return '0;
      return 17'(m >> k);
   endfunction

   task automatic softmax_reset_state();
      vec_count = 0;
      vec_max = -16'sd32768;
      vec_dropped = 1'b0;
   endtask

   // Fold one accepted element in; on last, queue the vector's probabilities.
   task automatic softmax_accept(input logic [15:0] v, input logic lst);
      logic [23:0] sum;
      logic [63:0] e, p;
      logic [15:0] n;
      prob_item_type it;
      if (vec_count < MaxLen) begin
         vec_store[vec_count] = v;
         vec_count++;
         if ($signed(v) > vec_max) vec_max = $signed(v);
      end else begin
         vec_dropped = 1'b1;
      end
      if (!lst) return;
      sum = '0;
      for (int i = 0; i < vec_count; i++) begin
         n = vec_max - $signed(vec_store[i]);
         sum = sum + {7'd0, exp_neg(n)};
      end
      for (int i = 0; i < vec_count; i++) begin
         n = vec_max - $signed(vec_store[i]);
         e = {47'd0, exp_neg(n)};
         p = '0;
         if (sum != 0) begin
            p = ((e << 16) + {41'd0, sum >> 1}) / {40'd0, sum};
            if (p > 65535) p = 65535;
         end
         it.prob = p[15:0];
         it.last = (i + 1 == vec_count);
         it.trunc = vec_dropped;
         prob_queue.push_back(it);
      end
      vectors_closed++;
      softmax_reset_state();
   endtask

   // Receiver: random stall, checks every result transaction
   always @(posedge clock) begin
      prob_item_type want;
      logic [16:0] fixed;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (prob_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transaction: prob=%0d last=%0b trunc=%0b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = prob_queue.pop_front();
               fixed = (fixed_prob.size() > 0) ? fixed_prob.pop_front() : 17'd0;
               if (fixed[16] && fixed[15:0] != want.prob) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("typed-in probability %0d disagrees with predictor %0d",
                              fixed[15:0], want.prob);
               end
               if (rsp_tdata !== want.prob || rsp_tlast !== want.last
                   || rsp_tuser !== want.trunc) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: exp prob=%0d last=%0b trunc=%0b, got %0d %0b %0b",
                              want.prob, want.last, want.trunc,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         rsp_tready <= quiet_idle ? 1'b1 : ($urandom_range(99) >= 27);
      end
   end

   // Watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
         $display("watchdog: no transaction for %0d cycles", WatchLimit);
         $display("** softmax_vector: FAILED **");
         $finish;
      end
   end

   // Send one element; valid may idle before it, per the idling rate.
   task automatic send_elem(input logic [15:0] v, input logic lst);
      while (!quiet_idle && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      softmax_accept(v, lst);
   endtask

   function automatic logic [15:0] rand_elem(input int style, input logic [15:0] base);
      case (style)
         0: return 16'($urandom);
         1: return 16'(base + $urandom_range(1024) - 512);   // close values, shared mass
         2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
         default: return 16'(base + $urandom_range(64) - 32);
      endcase
   endfunction

   dir_row_type dir_tab [DirRows];

   initial begin
      int len, style, sent;
      logic [15:0] base;
      // single-element vectors give exactly 65536/65536, saturated to 65535
      dir_tab[0]  = '{16'h0000, 1'b1, 1'b1, 16'd65535};
      dir_tab[1]  = '{16'h7FFF, 1'b1, 1'b1, 16'd65535};
      dir_tab[2]  = '{16'h8000, 1'b1, 1'b1, 16'd65535};
      // two equal elements split evenly
      dir_tab[3]  = '{16'h0100, 1'b0, 1'b1, 16'd32768};
      dir_tab[4]  = '{16'h0100, 1'b1, 1'b1, 16'd32768};
      // full-range gap: the small one underflows to zero
      dir_tab[5]  = '{16'h8000, 1'b0, 1'b1, 16'd0};
      dir_tab[6]  = '{16'h7FFF, 1'b1, 1'b1, 16'd65535};
      // mixed-sign short vector, predictor only
      dir_tab[7]  = '{16'hFF00, 1'b0, 1'b0, 16'd0};
      dir_tab[8]  = '{16'h0080, 1'b0, 1'b0, 16'd0};
      dir_tab[9]  = '{16'h5555, 1'b0, 1'b0, 16'd0};
      dir_tab[10] = '{16'hAAAA, 1'b0, 1'b0, 16'd0};
      dir_tab[11] = '{16'h0001, 1'b0, 1'b0, 16'd0};
      dir_tab[12] = '{16'h0000, 1'b1, 1'b0, 16'd0};
      // small gaps exercise interpolation
      for (int i = 13; i < DirRows; i++)
         dir_tab[i] = '{16'h0200 + 16'(i * 37), (i == DirRows - 1), 1'b0, 16'd0};

      softmax_reset_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // typed values map one per result in order; queued before the row goes out
      for (int i = 0; i < DirRows; i++) begin
         fixed_prob.push_back({dir_tab[i].has_prob, dir_tab[i].prob});
         send_elem(dir_tab[i].value, dir_tab[i].last);
      end

      // store-full case: 64 kept, overflow dropped, last on a dropped element
      for (int i = 0; i < 70; i++) send_elem(16'(i * 113), i == 69);
      for (int i = 0; i < 64; i++) fixed_prob.push_back(17'd0);
      // exactly full store
      for (int i = 0; i < 64; i++) send_elem(16'($urandom), i == 63);
      for (int i = 0; i < 64; i++) fixed_prob.push_back(17'd0);

      sent = 0;
      while (sent < RandItems) begin
         quiet_idle = (sent >= 200 && sent < 280);
         len = ($urandom_range(9) == 0) ? $urandom_range(66, 40) : $urandom_range(12, 1);
         style = $urandom_range(3);
         base = 16'($urandom);
         for (int i = 0; i < len; i++) begin
            send_elem(rand_elem(style, base), i == len - 1);
            fixed_prob.push_back(17'd0);
         end
         sent += len;
      end
      quiet_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (prob_queue.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("covered %0d vectors, %0d probabilities checked, incl. store-full and saturation",
               vectors_closed, rsp_seen);
      if (mismatches == 0 && prob_queue.size() == 0)
         $display("** softmax_vector: PASSED **");
      else
         $display("** softmax_vector: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
